// File: hw/rtl/running_stats_accumulator_defines.svh
// -----------------------------------------------------------------------------
// Running stats accumulator assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// -----------------------------------------------------------------------------
`ifndef RUNNING_STATS_ACCUMULATOR_DEFINES_SVH
`define RUNNING_STATS_ACCUMULATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define RSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RSA_ASSERT(lbl, prop, msg)
`define RSA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/rsa_pkg.sv
// -----------------------------------------------------------------------------
// Running stats accumulator package
// Shared widths, codes and request/result types.
// -----------------------------------------------------------------------------
`default_nettype none
package rsa_pkg;
  localparam int MAX_METRICS_DEF = 16;
  localparam int IDX_W   = 4;
  localparam int VAL_W   = 24;
  localparam int CNT_W   = 16;
  localparam int SUM_W   = 40;
  localparam int SQ_W    = 63;
  localparam int CFG_W   = 5;
  localparam int VAR_W   = 64;
  localparam int DIV_W   = 80;
  localparam int STEP_W  = $clog2(DIV_W + 1);
  localparam int QDEPTH  = 2;
  localparam logic [CFG_W-1:0] METRICS_RESET = 5'd10;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [VAL_W-1:0] STD_MAX = '1;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_REPORT = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NOP    = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    OP_SAMPLE = 3'd0,
    OP_REPORT = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_NOP    = 3'd3,
    OP_ERROR  = 3'd4
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e                  op;
    logic [IDX_W-1:0]         idx;
    logic signed [VAL_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] std_v;
    logic [VAL_W-1:0] mean_v;
    logic [VAL_W-1:0] max_v;
    logic [VAL_W-1:0] min_v;
    logic [VAL_W-1:0] last_v;
    logic [VAL_W-1:0] first_v;
    logic [CNT_W-1:0] count;
    logic             index_error;
    logic             has_spread;
    logic             has_data;
  } result_t;
endpackage
`default_nettype wire

// File: hw/rtl/running_stats_accumulator.sv
// -----------------------------------------------------------------------------
// Running statistics accumulator
// Per-metric count, first/last/min/max, mean and sample std over a stream.
// -----------------------------------------------------------------------------
// Requests enter on the s_axis port and land in a two-entry command queue, so
// the upstream side keeps moving while the back end works; every request
// returns exactly one result on m_axis, in order. Clear, no-op and bad-index
// requests skip the arithmetic. A sample or report on a metric with one sample
// runs only the 40-step mean division. With two or more samples the
// bit-serial divider runs three times (40, 80 and 64 steps for mean, sum
// squared over n and the variance), and the 32-step square root follows.
// Stores are small per-metric arrays; count, sum and square sum carry one
// valid bit per metric, so a clear resets every metric at once and there is
// no clearing pass after reset. metrics_in_use must be written on the cfg
// port only while the block is idle; the block itself does not enforce this.
`default_nettype none
`include "running_stats_accumulator_defines.svh"
module running_stats_accumulator import rsa_pkg::*; #(
  parameter int MAX_METRICS = MAX_METRICS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // config: metrics_in_use
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  // request stream
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [3:0] metric_index, [27:4] sample_value, [28] sample_valid, [31:29] zero
  input  wire logic [31:0]      s_axis_tdata_i,
  // [1:0] req_type
  input  wire logic [1:0]       s_axis_tuser_i,
  // result stream
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  // [15:0] sample_count, [39:16] first_value, [63:40] last_value,
  // [87:64] min_value, [111:88] max_value, [135:112] mean_value,
  // [159:136] std_value
  output logic [159:0]          m_axis_tdata_o,
  // [0] has_data, [1] has_spread, [2] index_error
  output logic [2:0]            m_axis_tuser_o
);
  logic    cmd_valid, cmd_ready;
  cmd_t    cmd;
  result_t res;

  // front: config register, index check, request classification, queue
  rsa_front #(.MAX_METRICS(MAX_METRICS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_type_i   (s_axis_tuser_i),
    .in_idx_i    (s_axis_tdata_i[3:0]),
    .in_value_i  (s_axis_tdata_i[27:4]),
    .in_flag_i   (s_axis_tdata_i[28]),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // back: stores, update, divide and root sequencing, result register
  rsa_back #(.MAX_METRICS(MAX_METRICS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {res.std_v, res.mean_v, res.max_v, res.min_v,
                           res.last_v, res.first_v, res.count};
  assign m_axis_tuser_o = {res.index_error, res.has_spread, res.has_data};

  // back end never takes a command while a result waits
  `RSA_ASSERT(a_no_pop_while_out, (m_axis_tvalid_o |-> !cmd_ready), "pop during output")
  // queue only drains through a pop
  `RSA_ASSERT(a_queue_drain, ($fell(cmd_valid) |-> $past(cmd_ready)), "queue lost entry")
  // index errors carry no statistics
  `RSA_ASSERT(a_err_empty, (m_axis_tvalid_o && res.index_error |-> !res.has_data), "error data")
  // result is released right after the handshake
  `RSA_ASSERT_NEXT(a_out_release, m_axis_tvalid_o && m_axis_tready_i, !m_axis_tvalid_o, "result repeated")
endmodule
`default_nettype wire

// File: hw/rtl/rsa_front.sv
// -----------------------------------------------------------------------------
// Running stats front end
// Accepts requests, checks the index, classifies and queues them.
// -----------------------------------------------------------------------------
`default_nettype none
module rsa_front import rsa_pkg::*; #(
  parameter int MAX_METRICS = MAX_METRICS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       in_type_i,
  input  wire logic [IDX_W-1:0] in_idx_i,
  input  wire logic [VAL_W-1:0] in_value_i,
  input  wire logic             in_flag_i,
  output logic                  cmd_valid_o,
  input  wire logic             cmd_ready_i,
  output cmd_t                  cmd_o
);
  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  logic [CFG_W-1:0] metrics_q;
  cmd_t             q_mem [QDEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             idx_ok, push, pop;
  cmd_t             cmd_new;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metrics_q <= METRICS_RESET;
    end else if (cfg_valid_i) begin
      metrics_q <= cfg_data_i;
    end
  end

  assign idx_ok = ({1'b0, in_idx_i} < metrics_q) && (32'(in_idx_i) < MAX_METRICS);

  always_comb begin
    cmd_new.idx   = in_idx_i;
    cmd_new.value = in_value_i;
    case (req_type_e'(in_type_i))
      REQ_SAMPLE: cmd_new.op = !idx_ok ? OP_ERROR : (in_flag_i ? OP_SAMPLE : OP_REPORT);
      REQ_REPORT: cmd_new.op = idx_ok ? OP_REPORT : OP_ERROR;
      REQ_CLEAR:  cmd_new.op = OP_CLEAR;
      default:    cmd_new.op = OP_NOP;
    endcase
  end

  assign in_ready_o  = (cnt_q != CW'(QDEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/rsa_div.sv
// -----------------------------------------------------------------------------
// Running stats divider
// Restoring radix-2 divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
`default_nettype none
module rsa_div import rsa_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIV_W-1:0]  num_i,   // dividend, MSB aligned
  input  wire logic [STEP_W-1:0] steps_i,
  input  wire logic [CNT_W-1:0]  den_i,
  output logic                   busy_o,
  output logic [DIV_W-1:0]       quot_o
);
  logic [DIV_W-1:0]  num_q;
  logic [CNT_W-1:0]  rem_q, den_q;
  logic [STEP_W-1:0] cnt_q;
  logic [CNT_W:0]    rem_sh;
  logic              ge;

  assign rem_sh = {rem_q, num_q[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign busy_o = (cnt_q != '0);
  assign quot_o = num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= steps_i;
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_o) begin
      num_q <= {num_q[DIV_W-2:0], ge};
      rem_q <= ge ? CNT_W'(rem_sh - {1'b0, den_q}) : CNT_W'(rem_sh);
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/rsa_sqrt.sv
// -----------------------------------------------------------------------------
// Running stats square root
// Digit-by-digit integer square root, one result bit per cycle.
// -----------------------------------------------------------------------------
`default_nettype none
module rsa_sqrt import rsa_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [VAR_W-1:0] rad_i,
  output logic                  busy_o,
  output logic [VAR_W/2-1:0]    root_o
);
  localparam int STEPS = VAR_W / 2;
  localparam int SW    = $clog2(STEPS + 1);

  logic [VAR_W-1:0] rem_q, res_q, bit_q, trial;
  logic [SW-1:0]    cnt_q;

  assign trial  = res_q + bit_q;
  assign busy_o = (cnt_q != '0);
  assign root_o = res_q[VAR_W/2-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= SW'(STEPS);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rad_i;
      res_q <= '0;
      bit_q <= {2'b01, {(VAR_W-2){1'b0}}};
    end else if (busy_o) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/rsa_back.sv
// -----------------------------------------------------------------------------
// Running stats back end
// Executes queued commands: store update, mean and standard deviation.
// -----------------------------------------------------------------------------
`default_nettype none
module rsa_back import rsa_pkg::*; #(
  parameter int MAX_METRICS = MAX_METRICS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  output logic      cmd_ready_o,
  input  wire cmd_t cmd_i,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output result_t   res_o
);
  localparam int AW = (MAX_METRICS > 1) ? $clog2(MAX_METRICS) : 1;

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_READ   = 14'b00000000000010,
    ST_UPD    = 14'b00000000000100,
    ST_MEAN   = 14'b00000000001000,
    ST_MEAN_W = 14'b00000000010000,
    ST_MUL    = 14'b00000000100000,
    ST_QDIV   = 14'b00000001000000,
    ST_QDIV_W = 14'b00000010000000,
    ST_VDIV   = 14'b00000100000000,
    ST_VDIV_W = 14'b00001000000000,
    ST_SQRT   = 14'b00010000000000,
    ST_SQRT_W = 14'b00100000000000,
    ST_OUT    = 14'b01000000000000,
    ST_SPARE  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] mcnt_q, mcnt_d;

  // per-metric stores
  logic [CNT_W-1:0]        cnt_mem [MAX_METRICS];
  logic signed [SUM_W-1:0] sum_mem [MAX_METRICS];
  logic [SQ_W-1:0]         sq_mem  [MAX_METRICS];
  logic signed [VAL_W-1:0] fst_mem [MAX_METRICS];
  logic signed [VAL_W-1:0] lst_mem [MAX_METRICS];
  logic signed [VAL_W-1:0] mn_mem  [MAX_METRICS];
  logic signed [VAL_W-1:0] mx_mem  [MAX_METRICS];
  logic [MAX_METRICS-1:0]  vld_q;

  logic [AW-1:0]           rd_addr, addr_q;
  logic                    rd_vld_q;
  logic [CNT_W-1:0]        rd_cnt_q, cnt_q, cnt_new;
  logic signed [SUM_W-1:0] rd_sum_q, sum_q, sum_new;
  logic [SQ_W-1:0]         rd_sq_q, sq_q, sq_new;
  logic signed [VAL_W-1:0] rd_fst_q, rd_lst_q, rd_mn_q, rd_mx_q;
  logic signed [VAL_W-1:0] fst_q, lst_q, mn_q, mx_q, fst_new, mn_new, mx_new, x;

  cmd_t             cmd_q;
  result_t          res_q, res_init;
  logic [VAL_W-1:0] x_abs;
  logic [SUM_W-1:0] a_abs, mq, mean_full;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      prod_q;
  logic [DIV_W-1:0] acc_q;
  logic [VAR_W-1:0] v_q, v_new, s2_ext;

  logic              div_start, div_busy, sqrt_start, sqrt_busy;
  logic [DIV_W-1:0]  div_num, div_quot;
  logic [STEP_W-1:0] div_steps;
  logic [CNT_W-1:0]  div_den;
  logic [VAR_W/2-1:0] root;

  logic pop, is_sample, wr_en;

  assign x         = cmd_q.value;
  assign x_abs     = x[VAL_W-1] ? VAL_W'(-x) : x;
  assign a_abs     = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : sum_q;
  assign pop       = cmd_valid_i && cmd_ready_o;
  assign is_sample = (cmd_q.op == OP_SAMPLE);
  assign wr_en     = (state_q == ST_UPD) && is_sample;
  assign rd_addr   = AW'(cmd_i.idx);

  // fresh result: all zero, error flag from the classified op
  always_comb begin
    res_init             = '0;
    res_init.index_error = (cmd_i.op == OP_ERROR);
  end

  // sample update of the working copy
  assign fst_new = (cnt_q == '0) ? x : fst_q;
  assign mn_new  = ((cnt_q == '0) || (x < mn_q)) ? x : mn_q;
  assign mx_new  = ((cnt_q == '0) || (x > mx_q)) ? x : mx_q;
  assign cnt_new = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
  assign sum_new = (cnt_q == COUNT_MAX) ? sum_q : sum_q + SUM_W'(x);
  assign sq_new  = (cnt_q == COUNT_MAX) ? sq_q : sq_q + SQ_W'(prod_q[2*VAL_W-1:0]);

  assign mq        = div_quot[SUM_W-1:0];
  assign mean_full = sum_q[SUM_W-1] ? SUM_W'(-mq) : mq;
  assign s2_ext    = VAR_W'(sq_q);
  assign v_new     = ((|div_quot[DIV_W-1:VAR_W]) || (div_quot[VAR_W-1:0] > s2_ext)) ?
                     '0 : s2_ext - div_quot[VAR_W-1:0];

  // shared 32x32 multiplier, registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_READ) begin
      mul_a = 32'(x_abs);
      mul_b = 32'(x_abs);
    end else if (state_q == ST_MUL) begin
      case (mcnt_q)
        2'd0: begin mul_a = a_abs[31:0]; mul_b = a_abs[31:0]; end
        2'd1: begin mul_a = a_abs[31:0]; mul_b = 32'(a_abs[SUM_W-1:32]); end
        2'd2: begin mul_a = 32'(a_abs[SUM_W-1:32]); mul_b = 32'(a_abs[SUM_W-1:32]); end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_steps = '0;
    div_den   = cnt_q;
    case (state_q)
      ST_MEAN: begin
        div_start = (cnt_q != '0);
        div_num   = {a_abs, {(DIV_W-SUM_W){1'b0}}};
        div_steps = STEP_W'(SUM_W);
      end
      ST_QDIV: begin
        div_start = 1'b1;
        div_num   = acc_q;
        div_steps = STEP_W'(DIV_W);
      end
      ST_VDIV: begin
        div_start = 1'b1;
        div_num   = {v_q, {(DIV_W-VAR_W){1'b0}}};
        div_steps = STEP_W'(VAR_W);
        div_den   = cnt_q - 1'b1;
      end
      default: ;
    endcase
  end

  assign sqrt_start = (state_q == ST_SQRT);

  rsa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .steps_i (div_steps),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  rsa_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (v_q),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  // control
  always_comb begin
    state_d = state_q;
    mcnt_d  = mcnt_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_SAMPLE, OP_REPORT: state_d = ST_READ;
            default:              state_d = ST_OUT;
          endcase
        end
      end
      ST_READ:   state_d = ST_UPD;
      ST_UPD:    state_d = ST_MEAN;
      ST_MEAN:   state_d = (cnt_q == '0) ? ST_OUT : ST_MEAN_W;
      ST_MEAN_W: begin
        if (!div_busy) begin
          state_d = (cnt_q > CNT_W'(1)) ? ST_MUL : ST_OUT;
          mcnt_d  = '0;
        end
      end
      ST_MUL: begin
        mcnt_d = mcnt_q + 1'b1;
        if (mcnt_q == 2'd3) begin
          state_d = ST_QDIV;
        end
      end
      ST_QDIV:   state_d = ST_QDIV_W;
      ST_QDIV_W: if (!div_busy) state_d = ST_VDIV;
      ST_VDIV:   state_d = ST_VDIV_W;
      ST_VDIV_W: if (!div_busy) state_d = ST_SQRT;
      ST_SQRT:   state_d = ST_SQRT_W;
      ST_SQRT_W: if (!sqrt_busy) state_d = ST_OUT;
      ST_OUT:    if (res_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mcnt_q  <= '0;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      mcnt_q  <= mcnt_d;
      if (pop && (cmd_i.op == OP_CLEAR)) begin
        vld_q <= '0;
      end else if (wr_en) begin
        vld_q[addr_q] <= 1'b1;
      end
    end
  end

  // stores: registered read at pop, write after update
  always_ff @(posedge clk_i) begin
    if (pop) begin
      rd_vld_q <= vld_q[rd_addr];
      rd_cnt_q <= cnt_mem[rd_addr];
      rd_sum_q <= sum_mem[rd_addr];
      rd_sq_q  <= sq_mem[rd_addr];
      rd_fst_q <= fst_mem[rd_addr];
      rd_lst_q <= lst_mem[rd_addr];
      rd_mn_q  <= mn_mem[rd_addr];
      rd_mx_q  <= mx_mem[rd_addr];
    end
    if (wr_en) begin
      cnt_mem[addr_q] <= cnt_new;
      sum_mem[addr_q] <= sum_new;
      sq_mem[addr_q]  <= sq_new;
      fst_mem[addr_q] <= fst_new;
      lst_mem[addr_q] <= x;
      mn_mem[addr_q]  <= mn_new;
      mx_mem[addr_q]  <= mx_new;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_q  <= cmd_i;
          addr_q <= rd_addr;
          res_q  <= res_init;
        end
      end
      ST_READ: begin
        cnt_q <= rd_vld_q ? rd_cnt_q : '0;
        sum_q <= rd_vld_q ? rd_sum_q : '0;
        sq_q  <= rd_vld_q ? rd_sq_q : '0;
        fst_q <= rd_fst_q;
        lst_q <= rd_lst_q;
        mn_q  <= rd_mn_q;
        mx_q  <= rd_mx_q;
      end
      ST_UPD: begin
        if (is_sample) begin
          cnt_q <= cnt_new;
          sum_q <= sum_new;
          sq_q  <= sq_new;
          fst_q <= fst_new;
          lst_q <= x;
          mn_q  <= mn_new;
          mx_q  <= mx_new;
        end
      end
      ST_MEAN: begin
        if (cnt_q != '0) begin
          res_q.count      <= cnt_q;
          res_q.first_v    <= fst_q;
          res_q.last_v     <= lst_q;
          res_q.min_v      <= mn_q;
          res_q.max_v      <= mx_q;
          res_q.has_data   <= 1'b1;
          res_q.has_spread <= (cnt_q > CNT_W'(1));
        end
      end
      ST_MEAN_W: begin
        if (!div_busy) begin
          res_q.mean_v <= mean_full[VAL_W-1:0];
          acc_q        <= '0;
        end
      end
      ST_MUL: begin
        case (mcnt_q)
          2'd1:    acc_q <= acc_q + DIV_W'(prod_q);
          2'd2:    acc_q <= acc_q + (DIV_W'(prod_q) << 33);
          2'd3:    acc_q <= acc_q + (DIV_W'(prod_q) << 64);
          default: ;
        endcase
      end
      ST_QDIV_W: if (!div_busy) v_q <= v_new;
      ST_VDIV_W: if (!div_busy) v_q <= div_quot[VAR_W-1:0];
      ST_SQRT_W: begin
        if (!sqrt_busy) begin
          res_q.std_v <= (|root[VAR_W/2-1:VAL_W]) ? STD_MAX : root[VAL_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_OUT);
  assign res_o       = res_q;
endmodule
`default_nettype wire

// File: verif/running_stats_checker.sv
// -----------------------------------------------------------------------------
// Running stats result checker
// Watches the request, config and result streams, predicts each result and
// compares its data word and flags against what the block returns.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module running_stats_checker import rsa_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_i,
  input  logic [4:0]     cfg_data_i,
  input  logic           s_tvalid_i,
  input  logic           s_tready_i,
  input  logic [31:0]    s_tdata_i,
  input  logic [1:0]     s_tuser_i,
  input  logic           m_tvalid_i,
  input  logic           m_tready_i,
  input  logic [159:0]   m_tdata_i,
  input  logic [2:0]     m_tuser_i,
  output int             fail_count_o,
  output int             pending_o
);
  localparam int NM = MAX_METRICS_DEF;

  typedef struct packed {
    logic [159:0] data;
    logic [2:0]   flags;
  } stats_word_t;

  logic [4:0]         tracked;
  logic [15:0]        cnt  [NM];
  logic signed [23:0] frst [NM];
  logic signed [23:0] lst  [NM];
  logic signed [23:0] mn   [NM];
  logic signed [23:0] mx   [NM];
  logic signed [39:0] sum  [NM];
  logic [62:0]        sq   [NM];
  stats_word_t        expected_stats [$];

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bits;
    res = '0;
    bits = 64'd1 << 62;
    while (bits > v) bits >>= 2;
    while (bits != 0) begin
      if (v >= res + bits) begin
        v = v - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res >>= 1;
      end
      bits >>= 2;
    end
    return res;
  endfunction

  function automatic stats_word_t metric_report(int m);
    stats_word_t w;
    logic [15:0] n;
    logic signed [39:0] mean;
    logic [79:0] mag, q;
    logic [63:0] v, sd;
    w = '0;
    n = cnt[m];
    w.data[15:0] = n;
    if (n != 0) begin
      w.data[39:16]   = frst[m];
      w.data[63:40]   = lst[m];
      w.data[87:64]   = mn[m];
      w.data[111:88]  = mx[m];
      mean = sum[m] / $signed({24'd0, n});  // truncates toward zero
      w.data[135:112] = mean[23:0];
      w.flags[0] = 1'b1;
      if (n > 1) begin
        mag = sum[m] < 0 ? 80'(-sum[m]) : 80'(sum[m]);
        q = (mag * mag) / 80'(n);
        // quotient beyond 64 bits or above the square sum floors to zero
        v = (q[79:64] != 0 || q[63:0] > 64'(sq[m])) ? 64'd0 : 64'(sq[m]) - q[63:0];
        sd = int_sqrt(v / 64'(n - 1));
        w.data[159:136] = sd > 64'hFFFFFF ? 24'hFFFFFF : sd[23:0];
        w.flags[1] = 1'b1;
      end
    end
    return w;
  endfunction

  task automatic predict_request(logic [1:0] kind, logic [31:0] d);
    stats_word_t w;
    int m;
    logic signed [23:0] x;
    w = '0;
    m = int'(d[3:0]);
    x = d[27:4];
    case (req_type_e'(kind))
      REQ_CLEAR: begin
        for (int i = 0; i < NM; i++) begin
          cnt[i] = '0;
          sum[i] = '0;
          sq[i] = '0;
        end
      end
      REQ_NOP: ;
      default: begin
        if (m >= tracked) begin
          w.flags[2] = 1'b1;
        end else begin
          if (req_type_e'(kind) == REQ_SAMPLE && d[28]) begin
            if (cnt[m] == 0) begin
              frst[m] = x;
              mn[m] = x;
              mx[m] = x;
            end
            lst[m] = x;
            if (x < mn[m]) mn[m] = x;
            if (x > mx[m]) mx[m] = x;
            if (cnt[m] != 16'hFFFF) begin
              cnt[m] = cnt[m] + 16'd1;
              sum[m] = sum[m] + 40'(x);
              sq[m] = sq[m] + 63'(48'(x * x));
            end
          end
          w = metric_report(m);
        end
      end
    endcase
    expected_stats = {expected_stats, w};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stats_word_t w;
    if (!rst_ni) begin
      tracked <= METRICS_RESET;
      for (int i = 0; i < NM; i++) begin
        cnt[i] = '0;
        sum[i] = '0;
        sq[i] = '0;
        frst[i] = '0;
        lst[i] = '0;
        mn[i] = '0;
        mx[i] = '0;
      end
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) tracked <= cfg_data_i;
      if (m_tvalid_i && m_tready_i) begin
        if (expected_stats.size() == 0) begin
          $display("%0t: unexpected result data=%h flags=%b", $time, m_tdata_i, m_tuser_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          w = expected_stats.pop_front();
          if (w.data !== m_tdata_i || w.flags !== m_tuser_i) begin
            $display("%0t: mismatch expected data=%h flags=%b actual data=%h flags=%b",
                     $time, w.data, w.flags, m_tdata_i, m_tuser_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) predict_request(s_tuser_i, s_tdata_i);
      pending_o <= expected_stats.size();
    end
  end
endmodule

// File: verif/running_stats_accumulator_tb.sv
// -----------------------------------------------------------------------------
// Running stats accumulator testbench
// Directed edge cases, then random sample bursts with reports and clears over
// several metric counts; a checker module predicts and compares every result.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module running_stats_accumulator_tb;
  import rsa_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [4:0]   cfg_data_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [31:0]  s_axis_tdata_i = '0;
  logic [1:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [159:0] m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;
  int           fail_count;
  int           pending;
  bit           long_hold = 1'b0;   // receiver held off to back up the queue

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  running_stats_accumulator DUT (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o
  );

  running_stats_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .s_tvalid_i(s_axis_tvalid_i), .s_tready_i(s_axis_tready_o),
    .s_tdata_i(s_axis_tdata_i), .s_tuser_i(s_axis_tuser_i),
    .m_tvalid_i(m_axis_tvalid_o), .m_tready_i(m_axis_tready_i),
    .m_tdata_i(m_axis_tdata_o), .m_tuser_i(m_axis_tuser_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Hand one request to the block; the valid stays up across back-to-back requests.
  task automatic send_request(req_type_e kind, int m, logic [23:0] x, bit valid);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {3'b000, valid, x, 4'(m)};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    // lets a trailing request finish before the next write
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_metrics(logic [4:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [23:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'($signed($urandom_range(0, 2000)) - 1000);
      default: return 24'($urandom);
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        m_axis_tready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
        long_hold = 1'b0;
      end
      g = gap_len();
      if (g > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    int m;
    logic [4:0] metric_counts [6];
    metric_counts = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd7, 5'd10};
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty reports, unused request, bad index, extremes, clear.
    send_request(REQ_REPORT, 0, 24'h0, 1'b0);
    send_request(REQ_NOP, 3, 24'h123456, 1'b1);
    send_request(REQ_SAMPLE, 10, 24'h7FFFFF, 1'b1);
    send_request(REQ_REPORT, 15, 24'h0, 1'b0);
    send_request(REQ_SAMPLE, 1, 24'h555555, 1'b0);
    send_request(REQ_SAMPLE, 1, 24'h800000, 1'b1);
    send_request(REQ_REPORT, 1, 24'h0, 1'b0);
    send_request(REQ_SAMPLE, 1, 24'h7FFFFF, 1'b1);
    send_request(REQ_SAMPLE, 1, 24'h7FFFFF, 1'b1);
    send_request(REQ_SAMPLE, 1, 24'h800000, 1'b1);
    send_request(REQ_SAMPLE, 9, 24'hFFFFFF, 1'b1);
    send_request(REQ_SAMPLE, 9, 24'h000001, 1'b1);
    send_request(REQ_REPORT, 9, 24'hAAAAAA, 1'b1);
    send_request(REQ_CLEAR, 0, 24'h0, 1'b0);
    send_request(REQ_REPORT, 1, 24'h0, 1'b0);
    send_request(REQ_SAMPLE, 2, 24'h000100, 1'b1);
    send_request(REQ_SAMPLE, 2, 24'h000100, 1'b1);
    send_request(REQ_REPORT, 2, 24'h0, 1'b0);
    drain_results();

    // Random phases over several metric counts, extremes among them.
    foreach (metric_counts[i]) begin
      write_metrics(metric_counts[i]);
      if (i == 3) long_hold = 1'b1;
      for (int k = 0; k < 70; k++) begin
        m = $urandom_range(0, 15);
        case ($urandom_range(0, 19))
          0:       send_request(REQ_CLEAR, m, 24'($urandom), 1'($urandom_range(0, 1)));
          1:       send_request(REQ_NOP, m, 24'($urandom), 1'($urandom_range(0, 1)));
          2, 3, 4: send_request(REQ_REPORT, m, 24'($urandom), 1'($urandom_range(0, 1)));
          default: send_request(REQ_SAMPLE, m, rand_value(), $urandom_range(0, 7) != 0);
        endcase
      end
      drain_results();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Stops the run as failed at 30 ms, a bound for the slowest run with long stalls and full reports.
  initial begin
    #30ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
